// ===== sv/c_style_escape_decoder_top_assert.svh =====
// Assertion macros for the escape decoder checker.
// Needs signals named clk and rst_n in the scope of use.
`ifndef C_STYLE_ESCAPE_DECODER_TOP_ASSERT_SVH
`define C_STYLE_ESCAPE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ced_pkg.sv =====
// Shared types, character constants and hex helper for the escape decoder.
// No dependencies.
package ced_pkg;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESC    = 2'd1,
        PH_HEX_HI = 2'd2,
        PH_HEX_LO = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNC_ESC = 3'd1,
        ST_TRUNC_HEX = 3'd2,
        ST_BAD_HEX   = 3'd3,
        ST_UNKNOWN   = 3'd4
    } status_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_DIGIT0    = 8'h30;
    localparam logic [7:0] CH_DIGIT9    = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;

    // Result queue depth; an item may push two results.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status_code;
        logic       last_result;
    } result_t;

    // What one item pushes into the result queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                 (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

// ===== sv/ced_ifs.sv =====
// Valid/ready channel interfaces for the escape decoder.
// Depends on ced_pkg for nothing; payload widths are fixed.
interface ced_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_string;

    modport source (output valid, in_byte, byte_present, end_of_string, input ready);
    modport sink   (input valid, in_byte, byte_present, end_of_string, output ready);
endinterface

interface ced_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [2:0] status_code;
    logic       last_result;

    modport source (output valid, out_byte, is_status, status_code, last_result, input ready);
    modport sink   (input valid, out_byte, is_status, status_code, last_result, output ready);
endinterface

// ===== sv/ced_decode.sv =====
// Combinational escape decode: next state and up to two results per item.
// Depends on ced_pkg.
module ced_decode
    import ced_pkg::*;
(
    input  phase_t      phase,
    input  logic [7:0]  held,
    input  status_t     err,
    input  logic [7:0]  in_byte,
    input  logic        byte_present,
    input  logic        end_of_string,
    output phase_t      phase_next,
    output logic [7:0]  held_next,
    output status_t     err_next,
    output push_t       push
);

    phase_t     phase_s;
    status_t    err_s;
    status_t    final_code;
    logic [7:0] held_s;
    logic       emit;
    logic [7:0] ch;
    logic [4:0] hi_val;
    logic [4:0] lo_val;

    assign hi_val = hex_value(held);
    assign lo_val = hex_value(in_byte);

    // Effect of the character itself.
    always_comb
    begin
        phase_s = phase;
        err_s   = err;
        held_s  = held;
        emit    = 1'b0;
        ch      = '0;
        if (byte_present && err == ST_OK)
        begin
            unique case (phase)
                PH_NORMAL:
                begin
                    if (in_byte == CH_BACKSLASH)
                    begin
                        phase_s = PH_ESC;
                    end
                    else
                    begin
                        emit = 1'b1;
                        ch   = in_byte;
                    end
                end
                PH_ESC:
                begin
                    phase_s = PH_NORMAL;
                    unique case (in_byte)
                        CH_BACKSLASH: begin emit = 1'b1; ch = CH_BACKSLASH; end
                        CH_N:         begin emit = 1'b1; ch = CH_LF; end
                        CH_R:         begin emit = 1'b1; ch = CH_CR; end
                        CH_T:         begin emit = 1'b1; ch = CH_TAB; end
                        CH_X:         phase_s = PH_HEX_HI;
                        default:      err_s = ST_UNKNOWN;
                    endcase
                end
                PH_HEX_HI:
                begin
                    held_s  = in_byte;
                    phase_s = PH_HEX_LO;
                end
                PH_HEX_LO:
                begin
                    phase_s = PH_NORMAL;
                    if (hi_val[4] || lo_val[4])
                    begin
                        err_s = ST_BAD_HEX;
                    end
                    else
                    begin
                        emit = 1'b1;
                        ch   = {hi_val[3:0], lo_val[3:0]};
                    end
                end
                default: phase_s = PH_NORMAL;
            endcase
        end
    end

    // Status judged after the character; pending escape counts as truncation.
    always_comb
    begin
        final_code = err_s;
        if (err_s == ST_OK)
        begin
            if (phase_s == PH_ESC)
            begin
                final_code = ST_TRUNC_ESC;
            end
            else if (phase_s == PH_HEX_HI || phase_s == PH_HEX_LO)
            begin
                final_code = ST_TRUNC_HEX;
            end
        end
    end

    // Next state: end of string returns everything to reset.
    always_comb
    begin
        if (end_of_string)
        begin
            phase_next = PH_NORMAL;
            held_next  = '0;
            err_next   = ST_OK;
        end
        else
        begin
            phase_next = phase_s;
            held_next  = held_s;
            err_next   = err_s;
        end
    end

    // Results: optional character, then optional status.
    always_comb
    begin
        result_t chr_res;
        result_t st_res;
        chr_res             = '0;
        chr_res.out_byte    = ch;
        st_res              = '0;
        st_res.is_status    = 1'b1;
        st_res.status_code  = final_code;
        st_res.last_result  = 1'b1;
        push.count  = {1'b0, emit} + {1'b0, end_of_string};
        push.first  = emit ? chr_res : st_res;
        push.second = st_res;
    end

endmodule

// ===== sv/ced_queue.sv =====
// Small result queue: takes up to two results per cycle, gives one.
// Depends on ced_pkg.
module ced_queue
    import ced_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    head_valid,
    output result_t head,
    input  logic    pop
);

    result_t        mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_next;
    logic [QAW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign room         = count_reg <= (QAW + 1)'(QDEPTH - 2);
    assign head_valid   = count_reg != '0;
    assign head         = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + QAW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QAW'(pop);
    assign count_next  = count_reg + (QAW + 1)'(push.count) - (QAW + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/c_style_escape_decoder_top.sv =====
// Top level of the C-style escape decoder: state registers, decode, result queue.
// Depends on ced_pkg, ced_ifs, ced_decode and ced_queue.
//
// Decodes a backslash-escaped string one character per item on the chars
// channel and delivers decoded bytes on the results channel. Supported escapes
// are \\, \n, \r, \t and \xHH (hex digits in either case). Each item gives at
// most two results: a decoded byte and, on the item flagged end_of_string, a
// status result (is_status = 1, last_result = 1) with the code 0 ok,
// 1 string ended after a backslash, 2 string ended within \x and fewer than two
// characters, 3 bad hex digit, 4 unknown escape. After the first error the rest
// of the string is dropped silently and only the status comes out. An item with
// byte_present low carries no character; with end_of_string it yields only the
// status, without it is ignored. Rate: one item per clock while the queue has
// room. Decode is a single pass of combinational logic on the phase /
// held-digit / error registers, and results go through a four-entry queue
// that drains one result per clock while the receiver is ready. The queue
// takes an item whenever at least two entries are free, so a stream that
// yields one result per item runs at full rate; an item that yields both a
// byte and a status adds one extra result on the output. Accepted results are
// queued in registers and offered from its head. No clearing pass after reset.
module c_style_escape_decoder_top
    import ced_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    ced_in_if.sink    chars,
    ced_out_if.source results
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    status_t    err_reg;
    status_t    err_next;

    push_t      dec_push;
    push_t      q_push;
    logic       room;
    logic       accept;
    logic       head_valid;
    result_t    head;

    ced_decode u_decode (
        .phase         (phase_reg),
        .held          (held_reg),
        .err           (err_reg),
        .in_byte       (chars.in_byte),
        .byte_present  (chars.byte_present),
        .end_of_string (chars.end_of_string),
        .phase_next    (phase_next),
        .held_next     (held_next),
        .err_next      (err_next),
        .push          (dec_push)
    );

    assign chars.ready = room;
    assign accept      = chars.valid && room;

    // Only an accepted item writes the queue.
    always_comb
    begin
        q_push = dec_push;
        if (!accept)
        begin
            q_push.count = 2'd0;
        end
    end

    ced_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (head_valid && results.ready)
    );

    assign results.valid       = head_valid;
    assign results.out_byte    = head.out_byte;
    assign results.is_status   = head.is_status;
    assign results.status_code = head.status_code;
    assign results.last_result = head.last_result;

    // Decode state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            held_reg  <= '0;
            err_reg   <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== sv/ced_checker.sv =====
// Port-level checks for the escape decoder, bound to the top level.
// Depends on ced_pkg and c_style_escape_decoder_top_assert.svh.
`include "c_style_escape_decoder_top_assert.svh"

module ced_checker
    import ced_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_status,
    input logic [2:0] status_code,
    input logic       last_result
);

    // Stalled result must hold.
    `CED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(is_status) && $stable(status_code), "result changed while stalled")

    // Only the status result closes a string.
    `CED_ASSERT_NOW(a_last_is_status, out_valid, last_result == is_status, "last_result and is_status disagree")

    // Character results carry no code.
    `CED_ASSERT_NOW(a_char_no_code, out_valid && !is_status, status_code == ST_OK, "code on a character result")

    // Status results carry no byte.
    `CED_ASSERT_NOW(a_status_no_byte, out_valid && is_status, out_byte == 8'd0, "byte on a status result")

endmodule

bind c_style_escape_decoder_top ced_checker u_ced_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_byte    (results.out_byte),
    .is_status   (results.is_status),
    .status_code (results.status_code),
    .last_result (results.last_result)
);

// ===== sim/tb_c_style_escape_decoder_top.sv =====
// Testbench for c_style_escape_decoder_top: directed and random escaped strings, with
// an in-bench decoder that predicts each item's results and checks them in order.
// Depends on ced_pkg, ced_ifs and the RTL of c_style_escape_decoder_top.
module tb_c_style_escape_decoder_top
    import ced_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Ways a random string is broken on purpose.
    typedef enum int {
        FLT_NONE,
        FLT_UNKNOWN,
        FLT_BAD_HEX,
        FLT_CUT_ESC,
        FLT_CUT_HEX0,
        FLT_CUT_HEX1
    } fault_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ced_in_if  chars_if ();
    ced_out_if results_if ();

    c_style_escape_decoder_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    // 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Decoder state as the block should hold it.
    phase_t  dec_phase;
    logic [7:0] held_hi;
    status_t err_code;

    // Results owed by the block, oldest first.
    result_t expected_results[$];

    int fail_count    = 0;
    int items_sent    = 0;  // items with a character or an end flag
    int tx_gap_max    = 17; // sender idle cycles drawn per item, 0..max
    int rx_stall_max  = 17; // receiver stall cycles drawn per result, 0..max
    int rx_hold_cycles = 0; // one-shot long hold-off, picked up by the receiver

    result_t want;
    bit      field_bad;

    task automatic flag_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t ERROR %s", $time, what);
        end
    endtask

    // Hex digit value in bits 3:0; bit 4 set when c is not a hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9)
        begin
            d = c - CH_DIGIT0;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            d = c - CH_LOWER_A + 8'd10;
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d = c - CH_UPPER_A + 8'd10;
        end
        else
        begin
            d = 8'h10;
        end
        return d[4:0];
    endfunction

    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10)
        begin
            return CH_DIGIT0 + v;
        end
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + v - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] n;
        do
        begin
            c = 8'($urandom_range(0, 255));
            n = nibble_of(c);
        end
        while (!n[4]);
        return c;
    endfunction

    function automatic void owe_byte(input logic [7:0] b);
        result_t r;
        r.out_byte    = b;
        r.is_status   = 1'b0;
        r.status_code = ST_OK;
        r.last_result = 1'b0;
        expected_results = {expected_results, r};
    endfunction

    // Work out what one accepted item yields and advance the decoder state.
    function automatic void decode_item(input logic [7:0] b, input logic p, input logic e);
        result_t r;
        logic [4:0] hi_n;
        logic [4:0] lo_n;
        if (p && err_code == ST_OK)
        begin
            case (dec_phase)
                PH_NORMAL:
                begin
                    if (b == CH_BACKSLASH)
                        dec_phase = PH_ESC;
                    else
                        owe_byte(b);
                end
                PH_ESC:
                begin
                    dec_phase = PH_NORMAL;
                    case (b)
                        CH_BACKSLASH: owe_byte(CH_BACKSLASH);
                        CH_N:         owe_byte(CH_LF);
                        CH_R:         owe_byte(CH_CR);
                        CH_T:         owe_byte(CH_TAB);
                        CH_X:         dec_phase = PH_HEX_HI;
                        default:      err_code = ST_UNKNOWN;
                    endcase
                end
                PH_HEX_HI:
                begin
                    held_hi   = b;
                    dec_phase = PH_HEX_LO;
                end
                default:
                begin
                    hi_n      = nibble_of(held_hi);
                    lo_n      = nibble_of(b);
                    dec_phase = PH_NORMAL;
                    if (hi_n[4] || lo_n[4])
                        err_code = ST_BAD_HEX;
                    else
                        owe_byte({hi_n[3:0], lo_n[3:0]});
                end
            endcase
        end
        if (e)
        begin
            // Length is judged before digits: an open escape ends as truncated.
            if (err_code == ST_OK)
            begin
                if (dec_phase == PH_ESC)
                    err_code = ST_TRUNC_ESC;
                else if (dec_phase == PH_HEX_HI || dec_phase == PH_HEX_LO)
                    err_code = ST_TRUNC_HEX;
            end
            r.out_byte    = 8'h00;
            r.is_status   = 1'b1;
            r.status_code = err_code;
            r.last_result = 1'b1;
            expected_results = {expected_results, r};
            dec_phase = PH_NORMAL;
            held_hi   = 8'h00;
            err_code  = ST_OK;
        end
    endfunction

    // Offer one item and wait for it to be taken. Called just after a rising edge;
    // returns just after the edge that accepted the item. Valid is left high so a
    // back-to-back item needs no second assignment in the same step.
    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid         <= 1'b1;
        chars_if.in_byte       <= b;
        chars_if.byte_present  <= p;
        chars_if.end_of_string <= e;
        @(posedge clk);
        while (!chars_if.ready) @(posedge clk);
        decode_item(b, p, e);
        if (p || e)
            items_sent++;
    endtask

    // Sender goes quiet until the block owes nothing.
    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Builds a well-formed string of random plain bytes and escapes, broken now and
    // then, and sends it with the end flag on the last character or on its own item.
    task automatic send_random_string();
        logic [7:0] text[$];
        logic [7:0] c;
        int ntok;
        int where_fault;
        int roll;
        int which;
        bit sep_end;
        fault_kind_t fault;
        ntok        = $urandom_range(0, 10);
        fault       = ($urandom_range(0, 99) < 20) ? fault_kind_t'($urandom_range(1, 5))
                                                    : FLT_NONE;
        where_fault = $urandom_range(0, ntok);
        for (int k = 0; k <= ntok; k++)
        begin
            if (fault != FLT_NONE && k == where_fault)
            begin
                text = {text, CH_BACKSLASH};
                if (fault == FLT_UNKNOWN)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c inside {CH_BACKSLASH, CH_N, CH_R, CH_T, CH_X});
                    text = {text, c};
                end
                else if (fault == FLT_BAD_HEX)
                begin
                    which = $urandom_range(0, 2);
                    text = {text, CH_X};
                    text = {text, (which == 1 ? hex_char() : non_hex_char())};
                    text = {text, (which == 0 ? hex_char() : non_hex_char())};
                end
                else
                begin
                    // Truncations end the string right here.
                    if (fault != FLT_CUT_ESC)
                        text = {text, CH_X};
                    if (fault == FLT_CUT_HEX1)
                        text = {text, ($urandom_range(0, 1) ? hex_char() : non_hex_char())};
                    break;
                end
            end
            if (k == ntok)
                break;
            roll = $urandom_range(0, 9);
            if (roll < 5)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_BACKSLASH)
                    c = c ^ 8'h01;
                text = {text, c};
            end
            else if (roll < 8)
            begin
                text = {text, CH_BACKSLASH};
                case ($urandom_range(0, 3))
                    0:       text = {text, CH_BACKSLASH};
                    1:       text = {text, CH_N};
                    2:       text = {text, CH_R};
                    default: text = {text, CH_T};
                endcase
            end
            else
            begin
                text = {text, CH_BACKSLASH};
                text = {text, CH_X};
                text = {text, hex_char()};
                text = {text, hex_char()};
            end
        end

        if (text.size() == 0)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        else
        begin
            sep_end = ($urandom_range(0, 3) == 0);
            foreach (text[i])
            begin
                // Occasional empty item in mid-string; the block must ignore it.
                if ($urandom_range(0, 31) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_item(text[i], 1'b1, !sep_end && (i == text.size() - 1));
            end
            if (sep_end)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Byte extremes, a plain pass-through string, the empty string and an ignored item.
    task automatic test_plain_and_empty();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);   // byte and status from one item
        send_item(8'hA5, 1'b0, 1'b1);   // empty string: status only
        send_item(8'hFF, 1'b0, 1'b0);   // no character, no end: ignored
        send_item("a", 1'b1, 1'b1);
    endtask

    task automatic test_simple_escapes();
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_N, 1'b1, 1'b0);
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_R, 1'b1, 1'b0);
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_T, 1'b1, 1'b1);
    endtask

    // Lower and upper case digits in one escape.
    task automatic test_hex_escapes();
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_X, 1'b1, 1'b0);
        send_item("f", 1'b1, 1'b0);
        send_item("A", 1'b1, 1'b1);
    endtask

    task automatic test_error_cases();
        // string ends on a backslash
        send_item("q", 1'b1, 1'b0);
        send_item(CH_BACKSLASH, 1'b1, 1'b1);
        // ends right after \x
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_X, 1'b1, 1'b1);
        // ends after \x and one non-digit: still truncated, not bad hex
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_X, 1'b1, 1'b0);
        send_item("g", 1'b1, 1'b1);
        // ends on an empty item while one hex digit is held
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_X, 1'b1, 1'b0);
        send_item("1", 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // bad high digit
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item(CH_X, 1'b1, 1'b0);
        send_item("g", 1'b1, 1'b0);
        send_item("1", 1'b1, 1'b1);
        // unknown escape, then a character that must be dropped
        send_item(CH_BACKSLASH, 1'b1, 1'b0);
        send_item("q", 1'b1, 1'b0);
        send_item("a", 1'b1, 1'b1);
    endtask

    // Bulk of the run; idling on both sides is switched off now and then.
    task automatic test_random_strings(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 17;
                rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            end
            send_random_string();
        end
        tx_gap_max   = 17;
        rx_stall_max = 17;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering items
    // back to back, so the result queue fills and input ready drops.
    task automatic test_full_stall(input int n_items);
        int stop_at;
        wait_drained();
        stop_at        = items_sent + n_items;
        rx_hold_cycles = 150;
        tx_gap_max     = 0;
        while (items_sent < stop_at)
            send_random_string();
        tx_gap_max = 17;
        wait_drained();
    endtask

    // Both sides at full rate.
    task automatic test_full_rate(input int n_items);
        int stop_at;
        stop_at      = items_sent + n_items;
        tx_gap_max   = 0;
        rx_stall_max = 0;
        while (items_sent < stop_at)
            send_random_string();
        tx_gap_max   = 17;
        rx_stall_max = 17;
    endtask

    // Unstructured items, biased toward escape characters, to hit odd orders.
    task automatic test_raw_items(input int n_items);
        int stop_at;
        logic [7:0] c;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1:    c = CH_BACKSLASH;
                2:       c = CH_X;
                3:       c = hex_char();
                4:
                begin
                    case ($urandom_range(0, 2))
                        0:       c = CH_N;
                        1:       c = CH_R;
                        default: c = CH_T;
                    endcase
                end
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_item(c, $urandom_range(0, 7) != 0, $urandom_range(0, 9) == 0);
        end
    endtask

    // Result checker: each taken result against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                flag_failure($sformatf("unexpected result byte=%h status=%b code=%0d last=%b",
                    results_if.out_byte, results_if.is_status, results_if.status_code,
                    results_if.last_result));
            end
            else
            begin
                want      = expected_results.pop_front();
                field_bad = (results_if.out_byte    !== want.out_byte)    ||
                            (results_if.is_status   !== want.is_status)   ||
                            (results_if.status_code !== want.status_code) ||
                            (results_if.last_result !== want.last_result);
                if (field_bad)
                begin
                    flag_failure($sformatf(
                        "result mismatch exp byte=%h st=%b code=%0d last=%b, got byte=%h st=%b code=%0d last=%b",
                        want.out_byte, want.is_status, want.status_code, want.last_result,
                        results_if.out_byte, results_if.is_status, results_if.status_code,
                        results_if.last_result));
                end
            end
        end
    end

    // Result receiver: random stall before each result, plus the long hold-off on
    // request, counted here in cycles.
    initial
    begin : rx_side
        int stall;
        results_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            @(posedge clk);
            while (!results_if.valid) @(posedge clk);
        end
    end

    // Main sequence.
    initial
    begin
        chars_if.valid         = 1'b0;
        chars_if.in_byte       = 8'h00;
        chars_if.byte_present  = 1'b0;
        chars_if.end_of_string = 1'b0;
        dec_phase = PH_NORMAL;
        held_hi   = 8'h00;
        err_code  = ST_OK;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_and_empty();
        test_simple_escapes();
        test_hex_escapes();
        test_error_cases();
        test_random_strings(1100);
        test_full_stall(80);
        test_full_rate(150);
        test_raw_items(300);

        // Drain, then allow for the block's latency before the verdict.
        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            flag_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0)
        begin
            $display("c_style_escape_decoder_top verification clean");
        end
        else
        begin
            $display("c_style_escape_decoder_top verification failed");
        end
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial
    begin
        #12_000_000;
        $display("c_style_escape_decoder_top verification failed");
        $finish;
    end

endmodule
